@@ hw/rtl/cfpq_pkg.sv @@
// Shared types, character codes and constants of the command frame parser queue.
// Used by every RTL module and the assertion checker.
`default_nettype none

package cfpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EXEC = 1'b1;

    localparam logic CFG_RESET_ID  = 1'b0;
    localparam logic CFG_SUPPLY_ID = 1'b1;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [7:0] MAGIC_P1 = 8'hAB;
    localparam logic [7:0] MAGIC_P2 = 8'hCD;
    localparam logic [7:0] MAGIC_P3 = 8'hEF;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic       frame_accepted;
        logic       frame_dropped;
        logic       executed;
        logic [7:0] executed_id;
        logic       reset_request;
        logic       supply_on;
        logic [3:0] queue_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] p3;
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] id;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } frame_t;

endpackage

`default_nettype wire

@@ hw/rtl/cfpq_stream_if.sv @@
// Valid/ready channel carrying one payload per transaction.
// The payload type is given per instance, normally a struct from cfpq_pkg.
`default_nettype none

interface cfpq_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/command_frame_parser_queue.sv @@
// Top level of the command frame parser queue: input register, parser, queue, result register.
// Depends on cfpq_pkg, cfpq_stream_if, cfpq_parser and cfpq_queue.
//
// Each input transaction is either one received character or an execute tick, and produces
// exactly one result transaction. The block takes one transaction per cycle while the sink
// does not stall: the item is captured in an input register, passes through the parser and
// queue logic, and lands in a result register that holds it while the sink stalls.
// Frames of the form $C,id,p1,p2,p3* are committed on the next CR or LF into a queue of
// QUEUE_DEPTH commands (2 to 15), kept in a memory with one write port and one registered
// read port whose head entry is prefetched every cycle. The user must write the two command ids
// through the configuration port only while the block is idle; the block does not enforce this.
`default_nettype none

module command_frame_parser_queue
    import cfpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    cfpq_stream_if.sink     in_ch,
    cfpq_stream_if.source   out_ch
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      fire;
    logic      in_ready;
    logic [7:0] reset_id_reg;
    logic [7:0] supply_id_reg;
    frame_t    frame;
    out_item_t result;

    assign advance  = !out_valid_reg || out_ch.ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    cfpq_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (fire && (in_item_reg.action == ACT_CHAR)),
        .char_code  (in_item_reg.char_code),
        .frame      (frame)
    );

    cfpq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_req   (fire && (in_item_reg.action == ACT_EXEC)),
        .frame     (frame),
        .reset_id  (reset_id_reg),
        .supply_id (supply_id_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_id_reg  <= 8'd0;
            supply_id_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_ID:  reset_id_reg  <= cfg_data;
                CFG_SUPPLY_ID: supply_id_reg <= cfg_data;
                default:       reset_id_reg  <= reset_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            in_item_reg <= in_ch.payload;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfpq_parser.sv @@
// Character-level frame parser: tracks the frame phase and accumulates the four fields.
// Depends on cfpq_pkg for character codes and the frame type.
`default_nettype none

module cfpq_parser
    import cfpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    input  wire logic [7:0] char_code,
    output frame_t          frame
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DOLLAR = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_FIELDS = 3'd3;
    localparam logic [2:0] PH_STAR   = 3'd4;

    localparam logic [1:0] FIELD_LAST = 2'd3;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [1:0] field_reg;
    logic [1:0] field_next;
    logic       closed_reg;
    logic       closed_next;
    logic [7:0] values_reg [4];
    logic [7:0] values_next [4];
    logic       line_end;
    logic       is_digit;
    logic [7:0] cur_value;
    logic [7:0] acc_value;
    logic       commit;

    assign line_end  = (char_code == CH_CR) || (char_code == CH_LF);
    assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign cur_value = values_reg[field_reg];
    assign acc_value = (cur_value << 3) + (cur_value << 1) + (char_code - CH_ZERO);

    always_comb
    begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        closed_next = closed_reg;
        values_next = values_reg;
        commit      = 1'b0;
        if (char_valid)
        begin
            if (char_code == CH_DOLLAR)
            begin
                phase_next  = PH_DOLLAR;
                field_next  = '0;
                closed_next = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    values_next[i] = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_DOLLAR:
                    begin
                        if ((char_code == CH_UPPER_C) || (char_code == CH_LOWER_C))
                        begin
                            phase_next = PH_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HEADER:
                    begin
                        phase_next = (char_code == CH_COMMA) ? PH_FIELDS : PH_IDLE;
                    end
                    PH_FIELDS:
                    begin
                        priority if (char_code == CH_COMMA)
                        begin
                            if (field_reg == FIELD_LAST)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                field_next  = field_reg + 2'd1;
                                closed_next = 1'b0;
                            end
                        end
                        else if (char_code == CH_STAR)
                        begin
                            phase_next = (field_reg == FIELD_LAST) ? PH_STAR : PH_IDLE;
                        end
                        else if (line_end)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (is_digit)
                        begin
                            if (!closed_reg)
                            begin
                                values_next[field_reg] = acc_value;
                            end
                        end
                        else
                        begin
                            closed_next = 1'b1;
                        end
                    end
                    PH_STAR:
                    begin
                        if (line_end)
                        begin
                            commit     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign frame.valid  = commit;
    assign frame.cmd.id = values_reg[0];
    assign frame.cmd.p1 = values_reg[1];
    assign frame.cmd.p2 = values_reg[2];
    assign frame.cmd.p3 = values_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            field_reg  <= '0;
            closed_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                values_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            closed_reg <= closed_next;
            values_reg <= values_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfpq_queue.sv @@
// Command queue with a prefetched head entry, plus execution of the popped command.
// Depends on cfpq_pkg for the command, frame and result types.
`default_nettype none

module cfpq_queue
    import cfpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pop_req,
    input  wire frame_t     frame,
    input  wire logic [7:0] reset_id,
    input  wire logic [7:0] supply_id,
    output out_item_t       result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    cmd_t             rd_data_reg;
    cmd_t             byp_data_reg;
    logic             byp_valid_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] head_inc;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             supply_reg;
    logic             supply_next;
    logic [CNT_W:0]   wr_sum;
    logic [IDX_W-1:0] wr_addr;
    logic             full;
    logic             do_pop;
    logic             do_push;
    cmd_t             head_data;
    logic             is_reset_cmd;
    logic             magic_ok;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_pop    = pop_req && (count_reg != '0);
    assign do_push   = frame.valid && !full;
    assign head_data = byp_valid_reg ? byp_data_reg : rd_data_reg;

    assign wr_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign wr_addr = (wr_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                   ? IDX_W'(wr_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                   : IDX_W'(wr_sum);

    assign head_inc  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign head_next = do_pop ? head_inc : head_reg;

    assign is_reset_cmd = (head_data.id == reset_id);
    assign magic_ok     = (head_data.p1 == MAGIC_P1) && (head_data.p2 == MAGIC_P2)
                       && (head_data.p3 == MAGIC_P3);

    always_comb
    begin
        count_next = count_reg;
        if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        supply_next = supply_reg;
        if (do_pop && !is_reset_cmd && (head_data.id == supply_id))
        begin
            supply_next = (head_data.p1 != '0);
        end
    end

    assign result.frame_accepted = do_push;
    assign result.frame_dropped  = frame.valid && full;
    assign result.executed       = do_pop;
    assign result.executed_id    = do_pop ? head_data.id : '0;
    assign result.reset_request  = do_pop && is_reset_cmd && magic_ok;
    assign result.supply_on      = supply_next;
    assign result.queue_count    = 4'(count_next);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_addr] <= frame.cmd;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= frame.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            supply_reg    <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            supply_reg    <= supply_next;
            byp_valid_reg <= do_push && (wr_addr == head_next);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfpq_checker.sv @@
// Port-level assertions for command_frame_parser_queue and the bind that attaches them.
// Depends on cfpq_pkg for the result type.
`default_nettype none

module cfpq_checker
    import cfpq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_payload
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result transaction changed while stalled");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({out_payload.frame_accepted, out_payload.frame_dropped,
                                out_payload.executed}))
        else $error("more than one queue event in one result");

    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.executed |-> out_payload.executed_id == 8'd0)
        else $error("executed_id set without an executed command");

    a_reset_exec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.reset_request |-> out_payload.executed)
        else $error("reset request without an executed command");

endmodule

bind command_frame_parser_queue cfpq_checker u_cfpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);

`default_nettype wire
